>>> rtl/vsr_pkg.sv
// ----------------------------------------------------------------------------
// vsr_pkg
// Shared types, sizes and arithmetic helpers for the vertex scatter/reduce
// engine: command codes, memory geometry and the scatter/reduce operators.
// ----------------------------------------------------------------------------
`default_nettype none

package vsr_pkg;

  localparam int VERTEX_COUNT = 65536;
  localparam int VALUE_W      = 32;

  localparam int VERTEX_W  = 16;
  localparam int LOAD_W    = 32;
  localparam int OUT_VAL_W = 32;
  localparam int WIDE_W    = 64;

  localparam int MEM_DEPTH = (VERTEX_COUNT < 65536) ? VERTEX_COUNT : 65536;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef logic [1:0]          cmd_t;
  typedef logic [VERTEX_W-1:0] vtx_t;
  typedef logic [LOAD_W-1:0]   load_t;
  typedef logic [OUT_VAL_W-1:0] out_val_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  localparam cmd_t CMD_LOAD = 2'd0;
  localparam cmd_t CMD_EDGE = 2'd1;
  localparam cmd_t CMD_SYNC = 2'd2;
  localparam cmd_t CMD_READ = 2'd3;

  localparam logic MODE_SUM = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  // read and write request for one property memory
  typedef struct packed {
    logic   re;
    addr_t  raddr;
    logic   we;
    addr_t  waddr;
    value_t wdata;
  } mem_req_t;

  // one result beat handed to the output stage
  typedef struct packed {
    logic     valid;
    vtx_t     vertex;
    out_val_t value;
    logic     changed;
  } res_t;

  function automatic logic vtx_ok(input vtx_t v);
    return ({1'b0, v} < (VERTEX_W+1)'(MEM_DEPTH));
  endfunction

  function automatic addr_t vtx_addr(input vtx_t v);
    return v[ADDR_W-1:0];
  endfunction

  function automatic value_t load_to_val(input load_t x);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(x);
    return t[VALUE_W-1:0];
  endfunction

  function automatic out_val_t val_to_out(input value_t v);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(v);
    return t[OUT_VAL_W-1:0];
  endfunction

  // min mode: plus one, saturating at all ones ("unreached")
  function automatic value_t scatter(input logic mode, input value_t v);
    if (mode == MODE_MIN) begin
      return (v == '1) ? v : v + value_t'(1);
    end
    return v;
  endfunction

  function automatic value_t reduce(input logic mode, input value_t acc, input value_t upd);
    if (mode == MODE_MIN) begin
      return (upd < acc) ? upd : acc;
    end
    return acc + upd;
  endfunction

endpackage

`default_nettype wire

>>> rtl/vertex_scatter_reduce_sync.sv
// ----------------------------------------------------------------------------
// vertex_scatter_reduce_sync
// Vertex property engine with current/next memories: load, edge reduce,
// sync and read commands over a valid/ready input and result channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a command (load, edge, sync, read), source and
//   destination vertex and a load value. Load and edge give no result; sync
//   and read give one result beat (vertex, value, changed flag).
//   cfg_wr_en writes reduce_mode (0 sum, 1 min with plus one) at once; write
//   it only while the engine is idle.
//   Each item first reads both memories (registered read data), then
//   modifies, writes back and hands off the result. in_ready is low while
//   an item executes, so a new item is taken only once the last is through;
//   the next item is taken while a result still sits in the output register.
//   The result is registered in the output register as the item leaves its
//   execute state, and the result beat is held there until taken.
//   If the receiver stalls with a result held in the output register, a
//   further sync or read waits in its execute cycle and the input stalls.
//   Reset clears control state and reduce_mode; memory contents are
//   undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_scatter_reduce_sync (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire vsr_pkg::cmd_t     in_cmd,
  input  wire vsr_pkg::vtx_t     in_src_vertex,
  input  wire vsr_pkg::vtx_t     in_dst_vertex,
  input  wire vsr_pkg::load_t    in_load_value,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      vsr_pkg::vtx_t     out_vertex_out,
  output      vsr_pkg::out_val_t out_value_out,
  output      logic              out_changed,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data
);
  import vsr_pkg::*;

  logic     reduce_mode_r;
  logic     out_valid_r, out_valid_nxt;
  vtx_t     out_vertex_r;
  out_val_t out_value_r;
  logic     out_changed_r;

  mem_req_t cur_req;
  mem_req_t nxt_req;
  value_t   cur_rdata;
  value_t   nxt_rdata;
  res_t     res;
  logic     res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reduce_mode_r <= MODE_SUM;
    end else if (cfg_wr_en) begin
      reduce_mode_r <= cfg_wr_data;
    end
  end

  vsr_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_src_vertex(in_src_vertex),
    .in_dst_vertex(in_dst_vertex),
    .in_load_value(in_load_value),
    .reduce_mode  (reduce_mode_r),
    .res_free     (res_free),
    .cur_rdata    (cur_rdata),
    .nxt_rdata    (nxt_rdata),
    .cur_req      (cur_req),
    .nxt_req      (nxt_req),
    .res          (res)
  );

  vsr_ram #(.DEPTH(MEM_DEPTH), .WIDTH(VALUE_W), .ADDR_W(ADDR_W)) u_cur_ram (
    .clk  (clk),
    .we   (cur_req.we),
    .waddr(cur_req.waddr),
    .wdata(cur_req.wdata),
    .re   (cur_req.re),
    .raddr(cur_req.raddr),
    .rdata(cur_rdata)
  );

  vsr_ram #(.DEPTH(MEM_DEPTH), .WIDTH(VALUE_W), .ADDR_W(ADDR_W)) u_nxt_ram (
    .clk  (clk),
    .we   (nxt_req.we),
    .waddr(nxt_req.waddr),
    .wdata(nxt_req.wdata),
    .re   (nxt_req.re),
    .raddr(nxt_req.raddr),
    .rdata(nxt_rdata)
  );

  // output register is free if empty or draining this cycle
  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_vertex_r  <= res.vertex;
      out_value_r   <= res.value;
      out_changed_r <= res.changed;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vertex_out = out_vertex_r;
  assign out_value_out  = out_value_r;
  assign out_changed    = out_changed_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid_r || out_ready))
    else $error("result overwrote a beat still waiting");

  a_res_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> out_valid)
    else $error("result beat lost");

  a_idle_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !res.valid) |=> !out_valid)
    else $error("result beat repeated");

endmodule

`default_nettype wire

>>> rtl/vsr_ram.sv
// ----------------------------------------------------------------------------
// vsr_ram
// Simple dual-port synchronous RAM: one write port, one read port, registered
// read data. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module vsr_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/vsr_seq.sv
// ----------------------------------------------------------------------------
// vsr_seq
// Item sequencer: takes one beat, reads both property memories, then
// modifies and writes back (load, edge reduce, sync) and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vsr_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire vsr_pkg::cmd_t     in_cmd,
  input  wire vsr_pkg::vtx_t     in_src_vertex,
  input  wire vsr_pkg::vtx_t     in_dst_vertex,
  input  wire vsr_pkg::load_t    in_load_value,
  input  wire logic              reduce_mode,
  input  wire logic              res_free,
  input  wire vsr_pkg::value_t   cur_rdata,
  input  wire vsr_pkg::value_t   nxt_rdata,
  output      vsr_pkg::mem_req_t cur_req,
  output      vsr_pkg::mem_req_t nxt_req,
  output      vsr_pkg::res_t     res
);
  import vsr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic    state_r, state_nxt;
  cmd_t    cmd_r;
  vtx_t    src_r;
  vtx_t    dst_r;
  load_t   ld_r;

  logic   accept;
  logic   has_res;
  logic   go;
  logic   src_ok;
  logic   dst_ok;
  value_t edge_val;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      src_r <= in_src_vertex;
      dst_r <= in_dst_vertex;
      ld_r  <= in_load_value;
    end
  end

  assign has_res  = (cmd_r == CMD_SYNC) || (cmd_r == CMD_READ);
  assign go       = !has_res || res_free;
  assign src_ok   = vtx_ok(src_r);
  assign dst_ok   = vtx_ok(dst_r);
  assign edge_val = reduce(reduce_mode, nxt_rdata, scatter(reduce_mode, cur_rdata));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // read both memories on the accept edge; the edge source goes to current
  always_comb begin
    cur_req.re    = accept;
    cur_req.raddr = vtx_addr((in_cmd == CMD_EDGE) ? in_src_vertex : in_dst_vertex);
    nxt_req.re    = accept;
    nxt_req.raddr = vtx_addr(in_dst_vertex);

    cur_req.waddr = vtx_addr(dst_r);
    nxt_req.waddr = vtx_addr(dst_r);
    cur_req.we    = 1'b0;
    nxt_req.we    = 1'b0;
    cur_req.wdata = nxt_rdata;
    nxt_req.wdata = edge_val;

    if (state_r == ST_EXEC && go && dst_ok) begin
      unique case (cmd_r)
        CMD_LOAD: begin
          cur_req.we    = 1'b1;
          cur_req.wdata = load_to_val(ld_r);
          nxt_req.we    = 1'b1;
          nxt_req.wdata = load_to_val(ld_r);
        end
        CMD_EDGE: nxt_req.we = src_ok;
        CMD_SYNC: cur_req.we = 1'b1;
        CMD_READ: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    res.valid   = (state_r == ST_EXEC) && has_res && res_free;
    res.vertex  = dst_r;
    res.value   = '0;
    res.changed = 1'b0;
    if (dst_ok) begin
      if (cmd_r == CMD_SYNC) begin
        res.value   = val_to_out(nxt_rdata);
        res.changed = (nxt_rdata != cur_rdata);
      end else begin
        res.value = val_to_out(cur_rdata);
      end
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted beat did not start execution");

  a_res_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (state_r == ST_EXEC) && ((cmd_r == CMD_SYNC) || (cmd_r == CMD_READ)))
    else $error("result from a command that gives none");

  a_cur_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cur_req.we |-> (state_r == ST_EXEC) && ((cmd_r == CMD_LOAD) || (cmd_r == CMD_SYNC)))
    else $error("unexpected write to current memory");

  a_no_read_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !cur_req.re && !nxt_req.re)
    else $error("memory read while an item executes");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vertex_scatter_reduce_sync. Drives load, edge, sync
// and read beats, randomly paced or back to back, on both channels. Keeps a
// shadow copy of the current/next property memories and the reduce mode, and
// checks every result beat against the oldest predicted report.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vsr_pkg::*;

  localparam int HOLD_CYCLES   = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;

  typedef struct {
    vtx_t     vtx;
    out_val_t val;
    logic     chg;
  } vertex_report_t;

  logic     clk           = 1'b0;
  logic     rst_n         = 1'b0;
  logic     in_valid      = 1'b0;
  logic     in_ready;
  cmd_t     in_cmd        = CMD_LOAD;
  vtx_t     in_src_vertex = '0;
  vtx_t     in_dst_vertex = '0;
  load_t    in_load_value = '0;
  logic     out_valid;
  logic     out_ready     = 1'b0;
  vtx_t     out_vertex_out;
  out_val_t out_value_out;
  logic     out_changed;
  logic     cfg_wr_en     = 1'b0;
  logic     cfg_wr_data   = 1'b0;

  // shadow state of the engine
  value_t  cur_props [MEM_DEPTH];
  value_t  nxt_props [MEM_DEPTH];
  bit      was_loaded [MEM_DEPTH];
  vtx_t    loaded_list [$];
  logic    mode_now = MODE_SUM;

  vertex_report_t reports_due [$];

  int   err_count    = 0;
  int   items_sent   = 0;
  bit   tx_pace      = 1'b1;
  bit   rx_pace      = 1'b1;
  int   rx_hold_ask  = 0;
  int   rx_hold_seen = 0;
  int   rx_hold_left = 0;
  int   rx_gap       = 0;
  int   quiet_cycles = 0;

  always #4 clk = ~clk;

  vertex_scatter_reduce_sync u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_src_vertex  (in_src_vertex),
    .in_dst_vertex  (in_dst_vertex),
    .in_load_value  (in_load_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_vertex_out (out_vertex_out),
    .out_value_out  (out_value_out),
    .out_changed    (out_changed),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    err_count++;
  endtask

  // Advance the shadow memories by one accepted beat; queue the report it owes.
  function automatic void apply_vertex_cmd(cmd_t c, vtx_t s, vtx_t d, load_t ld);
    value_t         upd;
    value_t         old_val;
    vertex_report_t r;
    bit             s_ok;
    bit             d_ok;
    s_ok = int'(s) < MEM_DEPTH;
    d_ok = int'(d) < MEM_DEPTH;
    case (c)
      CMD_LOAD: begin
        if (d_ok) begin
          cur_props[d] = value_t'(ld);
          nxt_props[d] = value_t'(ld);
        end
      end
      CMD_EDGE: begin
        if (s_ok && d_ok) begin
          upd = cur_props[s];
          if (mode_now == MODE_MIN) begin
            // all ones means unreached: hold it there
            if (upd != '1) upd = upd + 1'b1;
            if (upd < nxt_props[d]) nxt_props[d] = upd;
          end else begin
            nxt_props[d] = nxt_props[d] + upd;
          end
        end
      end
      default: begin
        r.vtx = d;
        r.val = '0;
        r.chg = 1'b0;
        if (d_ok && c == CMD_SYNC) begin
          old_val      = cur_props[d];
          cur_props[d] = nxt_props[d];
          r.val        = out_val_t'(nxt_props[d]);
          r.chg        = (nxt_props[d] != old_val);
        end else if (d_ok) begin
          r.val = out_val_t'(cur_props[d]);
        end
        reports_due.insert(reports_due.size(), r);
      end
    endcase
  endfunction

  function automatic vtx_t pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_item(cmd_t c, vtx_t s, vtx_t d, load_t ld);
    int gap;
    gap = tx_pace ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_src_vertex <= s;
    in_dst_vertex <= d;
    in_load_value <= ld;
    do @(posedge clk); while (!in_ready);
    apply_vertex_cmd(c, s, d, ld);
    if (c == CMD_LOAD && int'(d) < MEM_DEPTH && !was_loaded[d]) begin
      was_loaded[d] = 1'b1;
      loaded_list.insert(loaded_list.size(), d);
    end
    items_sent++;
  endtask

  // Drop valid, wait for all reports, then let trailing loads and edges retire.
  task automatic settle();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mode_now = m;
  endtask

  // Sum mode out of reset: wrap on overflow, self edge, unchanged sync.
  task automatic test_directed_sum();
    send_item(CMD_LOAD, 16'hFFFF, 16'h0000, 32'd5);
    send_item(CMD_LOAD, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 16'hA5A5, 16'h1234, 32'h8000_0000);
    send_item(CMD_EDGE, 16'h0000, 16'hFFFF, 32'h0000_0000);
    send_item(CMD_SYNC, 16'h5A5A, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_READ, 16'hFFFF, 16'hFFFF, 32'h1234_5678);
    send_item(CMD_SYNC, 16'h0000, 16'h0000, 32'h0);
    send_item(CMD_EDGE, 16'hFFFF, 16'h1234, 32'h0);
    send_item(CMD_EDGE, 16'h1234, 16'h1234, 32'h0);
    send_item(CMD_SYNC, 16'h0000, 16'h1234, 32'h0);
    send_item(CMD_READ, 16'h0000, 16'h1234, 32'h0);
  endtask

  // Min mode: unreached source saturates, back-to-back edges to one vertex.
  task automatic test_directed_min();
    set_mode(MODE_MIN);
    send_item(CMD_LOAD, 16'h0000, 16'h0001, 32'hFFFF_FFFF);
    send_item(CMD_EDGE, 16'h0001, 16'h0000, 32'h0);
    send_item(CMD_EDGE, 16'h0000, 16'h0001, 32'h0);
    send_item(CMD_EDGE, 16'h0000, 16'h0001, 32'h0);
    send_item(CMD_SYNC, 16'h0000, 16'h0001, 32'h0);
    send_item(CMD_SYNC, 16'h0000, 16'h0001, 32'h0);
    send_item(CMD_READ, 16'h0000, 16'h0001, 32'h0);
    send_item(CMD_SYNC, 16'h0000, 16'h0000, 32'h0);
  endtask

  // Receiver holds off while the sender keeps offering back to back.
  task automatic test_output_backpressure();
    vtx_t v;
    tx_pace = 1'b0;
    rx_hold_ask <= rx_hold_ask + 1;
    repeat (40) begin
      v = pick_loaded();
      case ($urandom_range(0, 2))
        0:       send_item(CMD_SYNC, vtx_t'($urandom), v, load_t'($urandom));
        1:       send_item(CMD_READ, vtx_t'($urandom), v, load_t'($urandom));
        default: send_item(CMD_EDGE, pick_loaded(), v, load_t'($urandom));
      endcase
    end
    settle();
  endtask

  // One propagation round: load a vertex group, then levels of edges and syncs,
  // with stray reads, syncs and edges from outside the group mixed in.
  task automatic run_propagation_round();
    vtx_t    group [$];
    vtx_t    v;
    load_t   init;
    int      n;
    int      first;
    n = $urandom_range(2, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = '1;
        2, 3:    v = (loaded_list.size() != 0) ? pick_loaded() : vtx_t'($urandom);
        default: v = vtx_t'($urandom);
      endcase
      if (mode_now == MODE_MIN) begin
        if (i == 0)                        init = load_t'($urandom_range(0, 20));
        else if ($urandom_range(0, 3) != 0) init = '1;
        else                               init = load_t'($urandom);
      end else begin
        init = ($urandom_range(0, 1) != 0) ? load_t'($urandom) : load_t'($urandom_range(0, 255));
      end
      group.insert(group.size(), v);
      send_item(CMD_LOAD, vtx_t'($urandom), v, init);
    end
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(n, 3 * n)) begin
        case ($urandom_range(0, 9))
          0: send_item(CMD_READ, vtx_t'($urandom), pick_loaded(), load_t'($urandom));
          1: send_item(CMD_SYNC, vtx_t'($urandom), pick_loaded(), load_t'($urandom));
          2: send_item(CMD_EDGE, pick_loaded(), group[$urandom_range(0, n - 1)],
                       load_t'($urandom));
          default: send_item(CMD_EDGE, group[$urandom_range(0, n - 1)],
                             group[$urandom_range(0, n - 1)], load_t'($urandom));
        endcase
      end
      first = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++)
        send_item(CMD_SYNC, vtx_t'($urandom), group[(first + i) % n], load_t'($urandom));
      if ($urandom_range(0, 1) != 0)
        send_item(CMD_READ, vtx_t'($urandom), group[$urandom_range(0, n - 1)],
                  load_t'($urandom));
    end
  endtask

  task automatic test_random_rounds(logic m, int count, bit paced);
    int target;
    set_mode(m);
    tx_pace = paced;
    rx_pace <= paced;
    target  = items_sent + count;
    while (items_sent < target) run_propagation_round();
  endtask

  // Receiver: per-beat random stall, or a long hold-off on request.
  always @(posedge clk) begin : result_sink
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_ask != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_ask;
      rx_hold_left <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (out_valid && out_ready) begin
      gap = rx_pace ? $urandom_range(0, 3) : 0;
      rx_gap    <= gap;
      out_ready <= (gap == 0);
    end else if (rx_gap > 0) begin
      rx_gap    <= rx_gap - 1;
      out_ready <= (rx_gap == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    vertex_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat for vertex %h", out_vertex_out));
      end else begin
        want = reports_due.pop_front();
        if (out_vertex_out !== want.vtx)
          report_mismatch($sformatf("vertex %h, want %h", out_vertex_out, want.vtx));
        if (out_value_out !== want.val)
          report_mismatch($sformatf("vertex %h value %h, want %h",
                                    want.vtx, out_value_out, want.val));
        if (out_changed !== want.chg)
          report_mismatch($sformatf("vertex %h changed %b, want %b",
                                    want.vtx, out_changed, want.chg));
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_sum();
    test_directed_min();
    test_output_backpressure();
    test_random_rounds(MODE_SUM, 300, 1'b1);
    test_random_rounds(MODE_MIN, 300, 1'b0);
    test_random_rounds(MODE_MIN, 300, 1'b1);
    test_random_rounds(MODE_SUM, 300, 1'b1);
    settle();
    if (reports_due.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", reports_due.size()));
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
